@@ sv/fcc_pkg.sv @@
`default_nettype none
package fcc_pkg;

  localparam int IDX_W   = 3;
  localparam int TAG_W   = 8;
  localparam int SIZE_W  = 32;
  localparam int COUNT_W = 32;
  localparam int ACT_W   = 2;
  localparam int CFG_W   = 4;

  localparam logic [ACT_W-1:0] ACT_RECORD = 2'd0;
  localparam logic [ACT_W-1:0] ACT_WRITE  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_READ   = 2'd2;

  localparam logic [SIZE_W-1:0] RST_BOUND0 = 32'd113154;
  localparam logic [SIZE_W-1:0] RST_BOUND1 = 32'd5671937;
  localparam logic [SIZE_W-1:0] RST_BOUND2 = 32'd1000000000;

  // token that walks the ring of cells
  typedef struct packed {
    logic [ACT_W-1:0]   action;
    logic [SIZE_W-1:0]  size;
    logic [IDX_W-1:0]   index;
    logic [TAG_W-1:0]   tag;
    logic [SIZE_W-1:0]  bound;
    logic               pass;   // 0: classify / write / read, 1: count
    logic               found;
    logic               hit;
    logic [COUNT_W-1:0] count;
  } tok_t;

  function automatic logic [SIZE_W-1:0] rst_bound(input int i);
    logic [SIZE_W-1:0] b;
    case (i)
      0:       b = RST_BOUND0;
      1:       b = RST_BOUND1;
      2:       b = RST_BOUND2;
      default: b = '0;
    endcase
    return b;
  endfunction

  function automatic logic [TAG_W-1:0] rst_tag(input int i);
    logic [TAG_W-1:0] t;
    case (i)
      0:       t = 8'd0;
      1:       t = 8'd1;
      2:       t = 8'd2;
      default: t = '0;
    endcase
    return t;
  endfunction

endpackage
`default_nettype wire

@@ sv/fcc_cell.sv @@
`default_nettype none
module fcc_cell #(
  parameter int          IDX       = 0,
  parameter int          BND_W     = 32,
  parameter logic [31:0] RST_BOUND = 32'd0,
  parameter logic [7:0]  RST_TAG   = 8'd0
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          active,
  input  logic          last,
  input  logic          vld_i,
  input  fcc_pkg::tok_t tok_i,
  output logic          vld_o,
  output fcc_pkg::tok_t tok_o
);
  import fcc_pkg::*;

  localparam logic             ADDRESSABLE = (IDX < (1 << IDX_W));
  localparam logic [IDX_W-1:0] MY_IDX      = IDX_W'(IDX % (1 << IDX_W));

  logic [BND_W-1:0]   bnd_r, bnd_nxt;
  logic [TAG_W-1:0]   tag_r, tag_nxt;
  logic [COUNT_W-1:0] cnt_r, cnt_nxt;
  logic [COUNT_W-1:0] cnt_inc;
  logic               vld_r;
  tok_t               tok_r, tok_nxt;
  logic               addr_hit;
  logic               size_le;

  assign addr_hit = ADDRESSABLE && (tok_i.index == MY_IDX);
  assign size_le  = tok_i.size <= SIZE_W'(bnd_r);
  assign cnt_inc  = (&cnt_r) ? cnt_r : cnt_r + COUNT_W'(1);

  always_comb begin
    tok_nxt = tok_i;
    bnd_nxt = bnd_r;
    tag_nxt = tag_r;
    cnt_nxt = cnt_r;
    if (vld_i) begin
      case (tok_i.action)
        ACT_RECORD: begin
          if (!tok_i.pass) begin
            // first bound that covers the size, else the last active entry
            if (active && !tok_i.found && (size_le || last)) begin
              tok_nxt.found = 1'b1;
              tok_nxt.tag   = tag_r;
            end
          end else if (active && !tok_i.hit && (tag_r == tok_i.tag)) begin
            cnt_nxt       = cnt_inc;
            tok_nxt.count = cnt_inc;
            tok_nxt.hit   = 1'b1;
          end
        end
        ACT_WRITE: begin
          if (!tok_i.pass && addr_hit) begin
            tag_nxt       = tok_i.tag;
            bnd_nxt       = tok_i.bound[BND_W-1:0];
            cnt_nxt       = '0;
            tok_nxt.found = 1'b1;
          end
        end
        ACT_READ: begin
          if (!tok_i.pass && addr_hit) begin
            tok_nxt.tag   = tag_r;
            tok_nxt.count = cnt_r;
            tok_nxt.found = 1'b1;
            cnt_nxt       = '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      bnd_r <= RST_BOUND[BND_W-1:0];
      tag_r <= RST_TAG;
      cnt_r <= '0;
    end else if (en) begin
      vld_r <= vld_i;
      bnd_r <= bnd_nxt;
      tag_r <= tag_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tok_r <= tok_nxt;
    end
  end

  assign vld_o = vld_r;
  assign tok_o = tok_r;

endmodule
`default_nettype wire

@@ sv/flow_size_class_counter.sv @@
`default_nettype none
// Flow size class counter. The class table lives in a ring of NUM_CLASSES
// cells, each holding one entry's bound, tag and load counter. An item is
// carried as a token around the ring twice, one cell per cycle: the first
// lap classifies a record (or performs a write / read at the addressed cell),
// the second lap counts the record on the first active entry with the chosen
// tag. An item therefore passes through every cell twice between acceptance and the
// output register, and the next item is taken once the result has moved into
// that register; a stalled output holds the ring. in_stall is high while a
// token is in the ring. active_classes is written through the cfg port while
// the block is idle.
module flow_size_class_counter #(
  parameter int NUM_CLASSES = 8,
  parameter int SIZE_BITS   = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [fcc_pkg::ACT_W-1:0]     in_action,
  input  logic [fcc_pkg::SIZE_W-1:0]    in_flow_size,
  input  logic [fcc_pkg::IDX_W-1:0]     in_entry_index,
  input  logic [fcc_pkg::TAG_W-1:0]     in_entry_tag,
  input  logic [fcc_pkg::SIZE_W-1:0]    in_entry_bound,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [fcc_pkg::TAG_W-1:0]     out_result_tag,
  output logic [fcc_pkg::COUNT_W-1:0]   out_result_count,
  output logic                          out_status,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [fcc_pkg::CFG_W-1:0]     cfg_active_classes
);
  import fcc_pkg::*;

  localparam int BND_W = (SIZE_BITS < SIZE_W) ? SIZE_BITS : SIZE_W;
  localparam logic [SIZE_W-1:0] SIZE_MASK = SIZE_W'((64'd1 << BND_W) - 64'd1);

  logic [CFG_W-1:0]     act_cls_r;
  logic [CFG_W-1:0]     live;
  logic [7:0]           lim;
  logic                 busy_r;
  logic                 acc_in;
  logic                 en;
  logic                 fin;
  logic                 wrap;
  tok_t                 launch_tok;
  tok_t                 wrap_tok;
  tok_t                 tok_c [NUM_CLASSES+1];
  logic [NUM_CLASSES:0] vld_c;
  logic [NUM_CLASSES-1:0] act_v;
  logic [NUM_CLASSES-1:0] last_v;

  logic                 out_vld_r;
  logic [TAG_W-1:0]     out_tag_r;
  logic [COUNT_W-1:0]   out_cnt_r;
  logic                 out_sts_r;

  // zero counts as one, large values clamp to the table size
  assign live = (act_cls_r == '0) ? CFG_W'(1) : act_cls_r;
  assign lim  = (8'(live) > 8'(NUM_CLASSES)) ? 8'(NUM_CLASSES) : 8'(live);

  assign acc_in    = in_valid && !in_stall;
  assign in_stall  = busy_r;
  assign cfg_ready = !busy_r;

  assign wrap = vld_c[NUM_CLASSES] && !tok_c[NUM_CLASSES].pass;
  assign en   = !(vld_c[NUM_CLASSES] && tok_c[NUM_CLASSES].pass && out_vld_r && out_stall);
  assign fin  = vld_c[NUM_CLASSES] && tok_c[NUM_CLASSES].pass && en;

  always_comb begin
    launch_tok        = '0;
    launch_tok.action = in_action;
    launch_tok.size   = in_flow_size & SIZE_MASK;
    launch_tok.index  = in_entry_index;
    launch_tok.bound  = in_entry_bound;
    if (in_action == ACT_RECORD) begin
      // a single active class always maps to tag 0
      launch_tok.tag   = '0;
      launch_tok.found = (lim == 8'd1);
    end else begin
      launch_tok.tag = in_entry_tag;
    end
    wrap_tok      = tok_c[NUM_CLASSES];
    wrap_tok.pass = 1'b1;
  end

  assign vld_c[0] = acc_in || wrap;
  assign tok_c[0] = wrap ? wrap_tok : launch_tok;

  for (genvar g = 0; g < NUM_CLASSES; g++) begin : g_cell
    assign act_v[g]  = 8'(g) < lim;
    assign last_v[g] = 8'(g) == (lim - 8'd1);

    fcc_cell #(
      .IDX       (g),
      .BND_W     (BND_W),
      .RST_BOUND (rst_bound(g)),
      .RST_TAG   (rst_tag(g))
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .active (act_v[g]),
      .last   (last_v[g]),
      .vld_i  (vld_c[g]),
      .tok_i  (tok_c[g]),
      .vld_o  (vld_c[g+1]),
      .tok_o  (tok_c[g+1])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_cls_r <= CFG_W'(1);
      busy_r    <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        act_cls_r <= cfg_active_classes;
      end
      if (acc_in) begin
        busy_r <= 1'b1;
      end else if (fin) begin
        busy_r <= 1'b0;
      end
      if (fin) begin
        out_vld_r <= 1'b1;
      end else if (out_vld_r && !out_stall) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fin) begin
      out_tag_r <= tok_c[NUM_CLASSES].found ? tok_c[NUM_CLASSES].tag : '0;
      out_cnt_r <= tok_c[NUM_CLASSES].count;
      out_sts_r <= (tok_c[NUM_CLASSES].action == ACT_RECORD) && !tok_c[NUM_CLASSES].hit;
    end
  end

  assign out_valid        = out_vld_r;
  assign out_result_tag   = out_tag_r;
  assign out_result_count = out_cnt_r;
  assign out_status       = out_sts_r;

`ifndef SYNTHESIS
  a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(vld_c[NUM_CLASSES:1]) <= 1)
    else $error("more than one token in the ring");

  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> (vld_c[NUM_CLASSES:1] == '0))
    else $error("token in the ring while idle");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    acc_in |=> busy_r && !fin)
    else $error("accepted transfer did not occupy the ring");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status |-> out_result_count == '0)
    else $error("missing tag reported with nonzero count");
`endif

endmodule
`default_nettype wire

@@ tb/tb_flow_size_class_counter.sv @@
`timescale 1ns / 1ps

module tb_flow_size_class_counter;
  import fcc_pkg::*;

  localparam int NUM_ENTRIES = 8;
  localparam int CYCLE_LIMIT = 500000;
  localparam int RANDOM_PHASE_ITEMS = 200;
  localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

  typedef struct packed {
    logic [ACT_W-1:0]  action;
    logic [SIZE_W-1:0] flow_size;
    logic [IDX_W-1:0]  index;
    logic [TAG_W-1:0]  tag;
    logic [SIZE_W-1:0] bound;
  } flow_item_t;

  typedef struct packed {
    logic [TAG_W-1:0]   tag;
    logic [COUNT_W-1:0] count;
    logic               status;
  } class_result_t;

  // Shadow of the class table; predicts one result per accepted item.
  class class_load_predictor;
    logic [SIZE_W-1:0]  size_bound [NUM_ENTRIES];
    logic [TAG_W-1:0]   class_tag [NUM_ENTRIES];
    logic [COUNT_W-1:0] load_count [NUM_ENTRIES];
    logic [CFG_W-1:0]   active_setting;
    class_result_t      awaited_results [$];
    int                 mismatches;

    function new();
      for (int i = 0; i < NUM_ENTRIES; i++) begin
        size_bound[IDX_W'(i)] = '0;
        class_tag[IDX_W'(i)]  = '0;
        load_count[IDX_W'(i)] = '0;
      end
      size_bound[0] = RST_BOUND0;
      size_bound[1] = RST_BOUND1;
      size_bound[2] = RST_BOUND2;
      class_tag[1] = 8'd1;
      class_tag[2] = 8'd2;
      active_setting = 4'd1;
      mismatches = 0;
    endfunction

    function int live_entries();
      if (active_setting == 0) return 1;
      if (active_setting > NUM_ENTRIES) return NUM_ENTRIES;
      return int'(active_setting);
    endfunction

    function void note_flow_item(flow_item_t it);
      int            n;
      logic [TAG_W-1:0] pick;
      logic          hit;
      class_result_t r;
      r = '0;
      case (it.action)
        ACT_RECORD: begin
          n = live_entries();
          pick = '0;
          if (n > 1) begin
            // fall back to the last active entry when no bound covers the size
            pick = class_tag[IDX_W'(n - 1)];
            hit = 1'b0;
            for (int i = 0; i < n && !hit; i++) begin
              if (it.flow_size <= size_bound[IDX_W'(i)]) begin
                pick = class_tag[IDX_W'(i)];
                hit = 1'b1;
              end
            end
          end
          r.tag = pick;
          r.status = 1'b1;
          hit = 1'b0;
          for (int i = 0; i < n && !hit; i++) begin
            if (class_tag[IDX_W'(i)] == pick) begin
              if (load_count[IDX_W'(i)] != '1) begin
                load_count[IDX_W'(i)] = load_count[IDX_W'(i)] + 1'b1;
              end
              r.count = load_count[IDX_W'(i)];
              r.status = 1'b0;
              hit = 1'b1;
            end
          end
        end
        ACT_WRITE: begin
          class_tag[it.index]  = it.tag;
          size_bound[it.index] = it.bound;
          load_count[it.index] = '0;
          r.tag = it.tag;
        end
        ACT_READ: begin
          r.tag = class_tag[it.index];
          r.count = load_count[it.index];
          load_count[it.index] = '0;
        end
        default: ;
      endcase
      awaited_results.push_back(r);
    endfunction

    function void check_result(logic [TAG_W-1:0] tag, logic [COUNT_W-1:0] count,
                               logic status);
      class_result_t want;
      if (awaited_results.size() == 0) begin
        $error("result transfer with nothing pending: tag %0h count %0h status %0b",
               tag, count, status);
        mismatches++;
        return;
      end
      want = awaited_results.pop_front();
      if (tag !== want.tag) begin
        $error("result_tag mismatch: expected %0h, actual %0h", want.tag, tag);
        mismatches++;
      end
      if (count !== want.count) begin
        $error("result_count mismatch: expected %0h, actual %0h", want.count, count);
        mismatches++;
      end
      if (status !== want.status) begin
        $error("status mismatch: expected %0b, actual %0b", want.status, status);
        mismatches++;
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [ACT_W-1:0]   in_action = ACT_RECORD;
  logic [SIZE_W-1:0]  in_flow_size = '0;
  logic [IDX_W-1:0]   in_entry_index = '0;
  logic [TAG_W-1:0]   in_entry_tag = '0;
  logic [SIZE_W-1:0]  in_entry_bound = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [TAG_W-1:0]   out_result_tag;
  logic [COUNT_W-1:0] out_result_count;
  logic               out_status;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [CFG_W-1:0]   cfg_active_classes = '0;

  int                 cycle_count = 0;
  logic               idle_on = 1'b1;
  class_load_predictor sb;

  flow_size_class_counter i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_action          (in_action),
    .in_flow_size       (in_flow_size),
    .in_entry_index     (in_entry_index),
    .in_entry_tag       (in_entry_tag),
    .in_entry_bound     (in_entry_bound),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_result_tag     (out_result_tag),
    .out_result_count   (out_result_count),
    .out_status         (out_status),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_active_classes (cfg_active_classes)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // valid stays high into the next item when that item has no gap
  task automatic send_item(input flow_item_t it);
    int unsigned gap;
    gap = idle_on ? $urandom_range(0, 4) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_action      <= it.action;
    in_flow_size   <= it.flow_size;
    in_entry_index <= it.index;
    in_entry_tag   <= it.tag;
    in_entry_bound <= it.bound;
    do @(posedge clk); while (in_stall);
    sb.note_flow_item(it);
  endtask

  task automatic send_fields(input logic [ACT_W-1:0] act, input logic [SIZE_W-1:0] size,
                             input logic [IDX_W-1:0] idx, input logic [TAG_W-1:0] tag,
                             input logic [SIZE_W-1:0] bound);
    flow_item_t it;
    it.action = act;
    it.flow_size = size;
    it.index = idx;
    it.tag = tag;
    it.bound = bound;
    send_item(it);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.awaited_results.size() != 0) @(posedge clk);
  endtask

  // only called with the block drained
  task automatic set_active_classes(input logic [CFG_W-1:0] value);
    repeat (2) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_active_classes <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.active_setting = value;
  endtask

  task automatic take_results();
    int unsigned hold;
    forever begin
      hold = idle_on ? $urandom_range(0, 4) : 0;
      if (idle_on && $urandom_range(0, 1) == 0) begin
        // stall on top of a held result
        out_stall <= 1'b1;
        do @(posedge clk); while (!out_valid);
        repeat (hold) @(posedge clk);
        out_stall <= 1'b0;
      end else if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!out_valid);
      sb.check_result(out_result_tag, out_result_count, out_status);
    end
  endtask

  // sizes land on, just above and just below the current bounds, or are zero, all ones or random
  function automatic logic [SIZE_W-1:0] pick_flow_size();
    logic [SIZE_W-1:0] b;
    b = sb.size_bound[IDX_W'($urandom_range(0, NUM_ENTRIES - 1))];
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3, 4: return b;
      5, 6:    return b + 1'b1;
      7:       return b - 1'b1;
      default: return $urandom();
    endcase
  endfunction

  function automatic flow_item_t make_random_item();
    flow_item_t  it;
    int unsigned sel;
    it.action = ACT_RECORD;
    it.flow_size = $urandom();
    it.index = IDX_W'($urandom_range(0, NUM_ENTRIES - 1));
    it.tag = TAG_W'($urandom_range(0, 255));
    it.bound = $urandom();
    sel = $urandom_range(0, 19);
    if (sel < 12) begin
      it.flow_size = pick_flow_size();
    end else if (sel < 16) begin
      it.action = ACT_WRITE;
      if ($urandom_range(0, 9) < 7) begin
        it.index = IDX_W'($urandom_range(0, sb.live_entries() - 1));
      end
      if ($urandom_range(0, 1) == 0) it.tag = TAG_W'($urandom_range(0, 3));
      case ($urandom_range(0, 19))
        0, 1, 2:             it.bound = '1;
        3, 4, 5:             it.bound = '0;
        6, 7, 8, 9, 10, 11:  it.bound = $urandom_range(0, 2000000);
        default:             ;
      endcase
    end else if (sel < 19) begin
      it.action = ACT_READ;
    end else begin
      it.action = ACT_UNUSED;
    end
    return it;
  endfunction

  initial begin
    logic [CFG_W-1:0] phase_setting [6];
    phase_setting = '{4'd8, 4'd2, 4'd5, 4'd9, 4'd1, 4'd7};
    sb = new();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    fork
      take_results();
    join_none

    // single active class
    set_active_classes(4'd1);
    send_fields(ACT_RECORD, '0, 3'd5, 8'h3c, 32'h1234_5678);
    send_fields(ACT_RECORD, '1, 3'd7, 8'hff, '1);
    send_fields(ACT_READ, '1, 3'd0, 8'hff, '1);
    send_fields(ACT_UNUSED, '1, 3'd7, 8'hff, '1);
    send_fields(ACT_WRITE, '0, 3'd0, 8'ha5, '0);
    // tag 0 no longer present
    send_fields(ACT_RECORD, 32'd77, 3'd0, 8'h00, '0);
    send_fields(ACT_WRITE, '0, 3'd0, 8'h00, RST_BOUND0);
    wait_drained();

    set_active_classes(4'd3);
    send_fields(ACT_RECORD, RST_BOUND0, 3'd0, 8'h00, '0);
    send_fields(ACT_RECORD, RST_BOUND0 + 1, 3'd0, 8'h00, '0);
    send_fields(ACT_RECORD, RST_BOUND1, 3'd0, 8'h00, '0);
    send_fields(ACT_RECORD, RST_BOUND2, 3'd0, 8'h00, '0);
    send_fields(ACT_RECORD, RST_BOUND2 + 1, 3'd0, 8'h00, '0);
    send_fields(ACT_RECORD, '0, 3'd0, 8'h00, '0);
    send_fields(ACT_READ, '0, 3'd1, 8'h00, '0);
    send_fields(ACT_READ, '0, 3'd2, 8'h00, '0);
    send_fields(ACT_READ, '0, 3'd7, 8'h00, '0);
    wait_drained();

    // zero acts as one
    set_active_classes(4'd0);
    send_fields(ACT_RECORD, 32'd5, 3'd0, 8'h00, '0);
    wait_drained();

    // above the table size acts as the full table
    set_active_classes(4'd15);
    send_fields(ACT_WRITE, '0, 3'd7, 8'hff, '1);
    send_fields(ACT_RECORD, 32'hffff_fffe, 3'd0, 8'h00, '0);
    send_fields(ACT_WRITE, '0, 3'd3, 8'h01, '0);
    send_fields(ACT_RECORD, '0, 3'd0, 8'h00, '0);
    send_fields(ACT_WRITE, '0, 3'd0, 8'h01, '0);
    send_fields(ACT_RECORD, '0, 3'd0, 8'h00, '0);
    send_fields(ACT_READ, '0, 3'd3, 8'h00, '0);
    wait_drained();

    for (int p = 0; p < 6; p++) begin
      idle_on = (p % 3 != 1);
      set_active_classes(phase_setting[p]);
      for (int k = 0; k < RANDOM_PHASE_ITEMS; k++) begin
        send_item(make_random_item());
        if ($urandom_range(0, 99) == 0) wait_drained();
      end
      wait_drained();
    end

    repeat (40) @(posedge clk);
    if (sb.mismatches == 0 && sb.awaited_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
